// File: sv/spq_pkg.sv
`timescale 1ns / 1ps
// shared types, widths and codes for the sorted priority queue
// no dependencies
package spq_pkg;

	localparam int DEPTH     = 16;
	localparam int PRIO_BITS = 8;
	localparam int DATA_BITS = 16;
	localparam int CAP_W     = 5;
	localparam int OCC_W     = 5;
	localparam int STAT_W    = 2;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int ENT_W     = PRIO_BITS + DATA_BITS;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	typedef logic [ADDR_W-1:0] pos_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic [PRIO_BITS-1:0] prio;
		logic [DATA_BITS-1:0] data;
	} entry_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SHIFT,
		S_PUT,
		S_POP
	} state_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_DONE  = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

endpackage

// File: sv/spq_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies
module spq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: sv/spq_step.sv
`timescale 1ns / 1ps
// shared step unit: priority compare and circular position step-back
// depends on spq_pkg
module spq_step import spq_pkg::*; (
	input  pos_t                 pos,
	input  cnt_t                 cap,
	input  logic [PRIO_BITS-1:0] slot_prio,
	input  logic [PRIO_BITS-1:0] new_prio,
	output pos_t                 prev_pos,
	output logic                 less
);

	cnt_t cap_m1;

	assign cap_m1   = cap - cnt_t'(1);
	assign prev_pos = (pos == '0) ? pos_t'(cap_m1) : pos - pos_t'(1);
	assign less     = slot_prio < new_prio;

endmodule

// File: sv/sorted_priority_queue.sv
`timescale 1ns / 1ps
// sorted priority queue: one command at a time, entries shifted one slot per cycle
// remove pops the head in S_POP; insert shifts lower-priority entries, then writes its entry
// refused commands (full / empty) return their result the cycle after start, busy stays low
// the result beat is registered and shown on done for one cycle; the receiver cannot stall
// reset empties the queue and sets capacity to 16; slot contents are undefined until written
module sorted_priority_queue import spq_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 cmd,
	input  logic [PRIO_BITS-1:0] priority_req,
	input  logic [DATA_BITS-1:0] payload,
	input  logic                 cfg_we,
	input  logic [CAP_W-1:0]     cfg_wdata,
	output logic                 done,
	output logic [PRIO_BITS-1:0] out_priority,
	output logic [DATA_BITS-1:0] out_payload,
	output logic [STAT_W-1:0]    status,
	output logic [OCC_W-1:0]     occupancy
);

	state_t                 state_q, state_d;
	logic [CAP_W-1:0]       cap_q;
	pos_t                   head_q;
	cnt_t                   fill_q;
	cnt_t                   off_q;
	pos_t                   to_q;
	pos_t                   from_q;
	logic [PRIO_BITS-1:0]   prio_q;
	logic [DATA_BITS-1:0]   data_q;
	logic                   done_q;
	logic [PRIO_BITS-1:0]   out_prio_q;
	logic [DATA_BITS-1:0]   out_data_q;
	status_t                status_q;
	logic [OCC_W-1:0]       occ_q;

	cnt_t                   cap_eff;
	logic [CNT_W:0]         start_sum;
	pos_t                   start_to;
	pos_t                   head_nxt;
	pos_t                   step_pos;
	pos_t                   step_prev;
	logic                   step_less;
	logic                   accept;
	logic                   is_full;
	logic                   ram_we;
	pos_t                   ram_waddr;
	pos_t                   ram_raddr;
	entry_t                 ram_wdata;
	entry_t                 ram_rdata;
	entry_t                 new_ent;

	// effective capacity, saturated to 1..DEPTH
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = cnt_t'(1);
		end else if (32'(cap_q) > DEPTH) begin
			cap_eff = cnt_t'(DEPTH);
		end else begin
			cap_eff = cnt_t'(cap_q);
		end
	end

	assign accept    = start && !busy;
	assign is_full   = fill_q >= cap_eff;
	assign start_sum = (CNT_W+1)'(head_q) + (CNT_W+1)'(fill_q);
	assign start_to  = (start_sum >= (CNT_W+1)'(cap_eff)) ?
		pos_t'(start_sum - (CNT_W+1)'(cap_eff)) : pos_t'(start_sum);
	assign head_nxt  = (cnt_t'(head_q) + cnt_t'(1) == cap_eff) ? '0 : head_q + pos_t'(1);
	assign step_pos  = (state_q == S_IDLE) ? start_to : from_q;
	assign new_ent   = '{prio: prio_q, data: data_q};

	spq_step u_step (
		.pos       (step_pos),
		.cap       (cap_eff),
		.slot_prio (ram_rdata.prio),
		.new_prio  (prio_q),
		.prev_pos  (step_prev),
		.less      (step_less)
	);

	spq_ram #(
		.WIDTH (ENT_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = to_q;
		ram_wdata = new_ent;
		ram_raddr = step_prev;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (cmd == CMD_INSERT) begin
						if (!is_full) begin
							state_d = (fill_q == '0) ? S_PUT : S_SHIFT;
						end
					end else begin
						ram_raddr = head_q;
						if (fill_q != '0) begin
							state_d = S_POP;
						end
					end
				end
			end
			S_SHIFT: begin
				ram_we = 1'b1;
				if (step_less) begin
					ram_wdata = ram_rdata;
					if (off_q == cnt_t'(1)) begin
						state_d = S_PUT;
					end
				end else begin
					state_d = S_IDLE;
				end
			end
			S_PUT: begin
				ram_we  = 1'b1;
				state_d = S_IDLE;
			end
			S_POP: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CAP_RESET;
			head_q <= '0;
			fill_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						prio_q <= priority_req;
						data_q <= payload;
						to_q   <= start_to;
						from_q <= step_prev;
						off_q  <= fill_q;
						if (cmd == CMD_INSERT && is_full) begin
							done_q     <= 1'b1;
							out_prio_q <= '0;
							out_data_q <= '0;
							status_q   <= STAT_FULL;
							occ_q      <= OCC_W'(fill_q);
						end else if (cmd == CMD_REMOVE && fill_q == '0) begin
							done_q     <= 1'b1;
							out_prio_q <= '0;
							out_data_q <= '0;
							status_q   <= STAT_EMPTY;
							occ_q      <= '0;
						end
					end
				end
				S_SHIFT: begin
					if (step_less) begin
						to_q   <= from_q;
						from_q <= step_prev;
						off_q  <= off_q - cnt_t'(1);
					end else begin
						done_q     <= 1'b1;
						out_prio_q <= '0;
						out_data_q <= '0;
						status_q   <= STAT_DONE;
						occ_q      <= OCC_W'(fill_q + cnt_t'(1));
						fill_q     <= fill_q + cnt_t'(1);
					end
				end
				S_PUT: begin
					done_q     <= 1'b1;
					out_prio_q <= '0;
					out_data_q <= '0;
					status_q   <= STAT_DONE;
					occ_q      <= OCC_W'(fill_q + cnt_t'(1));
					fill_q     <= fill_q + cnt_t'(1);
				end
				S_POP: begin
					done_q     <= 1'b1;
					out_prio_q <= ram_rdata.prio;
					out_data_q <= ram_rdata.data;
					status_q   <= STAT_DONE;
					occ_q      <= OCC_W'(fill_q - cnt_t'(1));
					fill_q     <= fill_q - cnt_t'(1);
					head_q     <= (fill_q == cnt_t'(1)) ? '0 : head_nxt;
				end
				default: begin
				end
			endcase
			// capacity write empties the queue
			if (cfg_we) begin
				cap_q  <= cfg_wdata;
				head_q <= '0;
				fill_q <= '0;
			end
		end
	end

	assign busy         = state_q != S_IDLE;
	assign done         = done_q;
	assign out_priority = out_prio_q;
	assign out_payload  = out_data_q;
	assign status       = status_q;
	assign occupancy    = occ_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= cap_eff)
		else $error("fill count above capacity");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_t'(head_q) < cap_eff)
		else $error("head position beyond wrap point");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q == '0 |-> head_q == '0)
		else $error("empty queue with nonzero head");

	a_full_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STAT_FULL) |-> occupancy == OCC_W'(cap_eff))
		else $error("full refusal with wrong occupancy");

	a_empty_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STAT_EMPTY) |-> (occupancy == '0 && out_priority == '0))
		else $error("empty refusal with wrong result");

endmodule
